FILE: design/rfm_pkg.sv
// rfm_pkg: words, register indexes and texture constants of the floor texel mapper.
// No dependencies; used by raycast_floor_texel_mapper and by verif/testbench.sv.
package rfm_pkg;

  typedef enum logic {REG_TEXTURE_SET = 1'b0, REG_PLAYER_DIST = 1'b1} reg_idx_t;

  localparam logic [3:0] FLOOR_TEX_A = 4'd4;
  localparam logic [3:0] FLOOR_TEX_B = 4'd10;
  localparam logic [3:0] CEIL_TEX_A  = 4'd5;
  localparam logic [3:0] CEIL_TEX_B  = 4'd11;
  localparam logic [23:0] MAX_Q816   = 24'hFFFFFF;
  localparam logic [17:0] MAX_WEIGHT = 18'h3FFFF;

  typedef struct packed {
    logic [10:0]        column;
    logic [8:0]         row;
    logic [7:0]         map_cell_x;
    logic [7:0]         map_cell_y;
    logic [15:0]        wall_hit_frac;
    logic               side;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic [23:0]        wall_distance;
    logic [23:0]        player_x;
    logic [23:0]        player_y;
  } in_word_t;

  typedef struct packed {
    logic [10:0] pixel_column;
    logic [8:0]  floor_row;
    logic [9:0]  ceiling_row;
    logic [5:0]  texel_x;
    logic [5:0]  texel_y;
    logic [3:0]  floor_texture;
    logic [3:0]  ceiling_texture;
    logic        bad_row;
  } out_word_t;

  // carried alongside the row distance divider
  typedef struct packed {
    logic [10:0] column;
    logic [8:0]  row;
    logic [24:0] wall_x;
    logic [24:0] wall_y;
    logic [23:0] player_x;
    logic [23:0] player_y;
    logic [24:0] den;
    logic        bad;
    logic        rsat;
  } rd_side_t;

  // carried alongside the weight divider
  typedef struct packed {
    logic [10:0] column;
    logic [8:0]  row;
    logic [24:0] wall_x;
    logic [24:0] wall_y;
    logic [23:0] player_x;
    logic [23:0] player_y;
    logic        bad;
    logic        wzero;
    logic        wsat;
  } wt_side_t;

  typedef struct packed {
    logic [10:0] column;
    logic [8:0]  row;
    logic        bad;
  } tail_t;

endpackage

FILE: design/rfm_div_pipe.sv
// rfm_div_pipe: restoring divider, one quotient bit per register stage.
// Quotient must fit in QW bits. Depends on nothing else.
module rfm_div_pipe #(
  parameter int NW = 40,
  parameter int DW = 24,
  parameter int QW = 18,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic          vld   [QW+1];
  logic [DW-1:0] rem   [QW+1];
  logic [NW-1:0] num_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [SW-1:0] side  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    rem[0]   <= DW'(num >> QW);
    num_q[0] <= num;
    den_q[0] <= den;
    quo_q[0] <= '0;
    side[0]  <= in_side;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    logic [DW:0] diff;
    always_comb begin
      trial = {rem[s], num_q[s][QW-1-s]};
      ge    = trial >= {1'b0, den_q[s]};
      diff  = trial - {1'b0, den_q[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1]   <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num_q[s+1] <= num_q[s];
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= {quo_q[s][QW-2:0], ge};
      side[s+1]  <= side[s];
    end
  end

  assign out_vld  = vld[QW];
  assign quo      = quo_q[QW];
  assign out_side = side[QW];

endmodule

FILE: design/rfm_blend.sv
// rfm_blend: blends wall point and player position by the weight, then takes the texel.
// Three register stages. Depends on nothing else.
module rfm_blend #(
  parameter int TEX_SIZE = 64
) (
  input  logic        clk,
  input  logic [17:0] weight,
  input  logic [24:0] wall,
  input  logic [23:0] player,
  output logic [5:0]  texel
);

  localparam int TW = $clog2(TEX_SIZE + 1);

  logic [42:0]        p_wall;
  logic signed [43:0] p_plr;
  logic signed [45:0] sum;
  logic signed [18:0] coef;
  logic [15:0]        frac;
  logic [TW+15:0]     prod;

  always_comb begin
    coef = 19'sh10000 - $signed({1'b0, weight});
    if (sum[45]) begin
      frac = '0;
    end else if (|sum[45:40]) begin
      frac = 16'hFFFF;
    end else begin
      frac = sum[31:16];
    end
    prod = (TW+16)'(frac) * (TW+16)'(TEX_SIZE);
  end

  always_ff @(posedge clk) begin
    p_wall <= 43'(weight) * 43'(wall);
    p_plr  <= coef * $signed({1'b0, player});
    sum    <= $signed({3'b0, p_wall}) + $signed({{2{p_plr[43]}}, p_plr});
    texel  <= 6'(prod >> 16);
  end

endmodule

FILE: design/raycast_floor_texel_mapper.sv
// raycast_floor_texel_mapper: floor/ceiling texel mapper for a column raycaster.
// Depends on rfm_pkg, rfm_div_pipe and rfm_blend.
//
// Usage: drive a word on item and pulse start; busy is always low, so a word is
// taken at every edge where start is high. One result word per input word appears
// on result with done high for one cycle, in input order, after passing through
// both dividers and the blend stages. Throughput is one word per clock: the row
// distance divider (24 stages) and the weight divider (18 stages) each resolve one
// quotient bit per stage, and the blend multipliers take three stages.
// The receiver cannot hold results off; done must be taken when it is shown.
// Registers sit on the APB port: texture_set at 0x0, player_distance at 0x4.
// Write them only while no word is in flight. Synchronous reset clears the
// registers and all valid bits; words in flight are dropped.
module raycast_floor_texel_mapper
  import rfm_pkg::*;
#(
  parameter int SCREEN_HEIGHT  = 512,
  parameter int TEXTURE_WIDTH  = 64,
  parameter int TEXTURE_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_word_t    item,
  output logic        done,
  output out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RN_W = $clog2(SCREEN_HEIGHT) + 17;
  localparam logic [RN_W-1:0] ROW_NUM = RN_W'(SCREEN_HEIGHT) << 16;

  logic        texture_set;
  logic [23:0] player_distance;

  // configuration
  logic       wr_en;
  reg_idx_t   wr_idx;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_set     <= 1'b0;
      player_distance <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_TEXTURE_SET: texture_set     <= pwdata[0];
        REG_PLAYER_DIST: player_distance <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_TEXTURE_SET: prdata = {31'b0, texture_set};
      REG_PLAYER_DIST: prdata = {8'b0, player_distance};
      default:         prdata = '0;
    endcase
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  assign busy = 1'b0;

  // entry: wall point, row denominator, weight divisor
  logic [24:0]        cx, cy, fr;
  logic signed [13:0] denom;
  logic signed [24:0] wden;
  logic [10:0]        rd_den;
  rd_side_t           e_side;

  always_comb begin
    cx     = {1'b0, item.map_cell_x, 16'b0};
    cy     = {1'b0, item.map_cell_y, 16'b0};
    fr     = {9'b0, item.wall_hit_frac};
    denom  = $signed({4'b0, item.row, 1'b0}) - $signed(14'(SCREEN_HEIGHT));
    wden   = $signed({1'b0, item.wall_distance}) - $signed({1'b0, player_distance});
    rd_den = denom[10:0];
    e_side.column   = item.column;
    e_side.row      = item.row;
    e_side.player_x = item.player_x;
    e_side.player_y = item.player_y;
    e_side.den      = wden;
    e_side.bad      = (denom <= 14'sd0) || (wden == 25'sd0);
    e_side.rsat     = {rd_den, 8'b0} <= 19'(SCREEN_HEIGHT);
    if (!item.side && !item.ray_dir_x[15] && (item.ray_dir_x != 16'sd0)) begin
      e_side.wall_x = cx;
      e_side.wall_y = cy + fr;
    end else if (!item.side && item.ray_dir_x[15]) begin
      e_side.wall_x = cx + 25'h10000;
      e_side.wall_y = cy + fr;
    end else if (item.side && item.ray_dir_y[15]) begin
      e_side.wall_x = cx + fr;
      e_side.wall_y = cy + 25'h10000;
    end else begin
      e_side.wall_x = cx + fr;
      e_side.wall_y = cy;
    end
  end

  logic        d1_vld;
  logic [23:0] d1_quo;
  logic [$bits(rd_side_t)-1:0] d1_raw;
  rd_side_t    d1_side;

  rfm_div_pipe #(.NW(RN_W), .DW(11), .QW(24), .SW($bits(rd_side_t))) u_row_div (
    .clk(clk), .rst(rst), .in_vld(start), .num(ROW_NUM), .den(rd_den),
    .in_side(e_side), .out_vld(d1_vld), .quo(d1_quo), .out_side(d1_raw)
  );
  assign d1_side = rd_side_t'(d1_raw);

  // weight operands
  logic [23:0]        rowdist;
  logic signed [24:0] wnum, wd;
  logic               num_pos, den_pos;
  logic [23:0]        an, ad;
  wt_side_t           p_side_next, p_side;
  logic               p_vld;
  logic [23:0]        p_an, p_ad;

  always_comb begin
    rowdist = d1_side.rsat ? MAX_Q816 : d1_quo;
    wnum    = $signed({1'b0, rowdist}) - $signed({1'b0, player_distance});
    wd      = $signed(d1_side.den);
    num_pos = !wnum[24] && (wnum != 25'sd0);
    den_pos = !wd[24] && (wd != 25'sd0);
    an      = wnum[24] ? 24'(-wnum) : wnum[23:0];
    ad      = wd[24] ? 24'(-wd) : wd[23:0];
    p_side_next.column   = d1_side.column;
    p_side_next.row      = d1_side.row;
    p_side_next.wall_x   = d1_side.wall_x;
    p_side_next.wall_y   = d1_side.wall_y;
    p_side_next.player_x = d1_side.player_x;
    p_side_next.player_y = d1_side.player_y;
    p_side_next.bad      = d1_side.bad;
    p_side_next.wzero    = (wnum == 25'sd0) || (num_pos != den_pos);
    p_side_next.wsat     = {2'b0, an} >= {ad, 2'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= d1_vld;
    end
    p_side <= p_side_next;
    p_an   <= an;
    p_ad   <= ad;
  end

  logic        d2_vld;
  logic [17:0] d2_quo;
  logic [$bits(wt_side_t)-1:0] d2_raw;
  wt_side_t    d2_side;
  logic [17:0] weight;

  rfm_div_pipe #(.NW(40), .DW(24), .QW(18), .SW($bits(wt_side_t))) u_wt_div (
    .clk(clk), .rst(rst), .in_vld(p_vld), .num({p_an, 16'b0}), .den(p_ad),
    .in_side(p_side), .out_vld(d2_vld), .quo(d2_quo), .out_side(d2_raw)
  );
  assign d2_side = wt_side_t'(d2_raw);
  assign weight  = d2_side.wzero ? 18'd0 : (d2_side.wsat ? MAX_WEIGHT : d2_quo);

  logic [5:0] tex_x, tex_y;

  rfm_blend #(.TEX_SIZE(TEXTURE_WIDTH)) u_blend_x (
    .clk(clk), .weight(weight), .wall(d2_side.wall_x), .player(d2_side.player_x),
    .texel(tex_x)
  );
  rfm_blend #(.TEX_SIZE(TEXTURE_HEIGHT)) u_blend_y (
    .clk(clk), .weight(weight), .wall(d2_side.wall_y), .player(d2_side.player_y),
    .texel(tex_y)
  );

  // sideband alongside the blend stages
  logic  t_vld [3];
  tail_t tail  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld[0] <= 1'b0;
      t_vld[1] <= 1'b0;
      t_vld[2] <= 1'b0;
    end else begin
      t_vld[0] <= d2_vld;
      t_vld[1] <= t_vld[0];
      t_vld[2] <= t_vld[1];
    end
    tail[0] <= '{column: d2_side.column, row: d2_side.row, bad: d2_side.bad};
    tail[1] <= tail[0];
    tail[2] <= tail[1];
  end

  always_comb begin
    done                   = t_vld[2];
    result.pixel_column    = tail[2].column;
    result.floor_row       = tail[2].row;
    result.ceiling_row     = (32'(tail[2].row) > SCREEN_HEIGHT) ? 10'd0 :
                             10'(SCREEN_HEIGHT - 32'(tail[2].row));
    result.texel_x         = tail[2].bad ? 6'd0 : tex_x;
    result.texel_y         = tail[2].bad ? 6'd0 : tex_y;
    result.floor_texture   = texture_set ? FLOOR_TEX_B : FLOOR_TEX_A;
    result.ceiling_texture = texture_set ? CEIL_TEX_B : CEIL_TEX_A;
    result.bad_row         = tail[2].bad;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for raycast_floor_texel_mapper: directed and random pixel words checked
// against an in-bench predictor of the texel mapping. Depends on rfm_pkg and the design.
module testbench;
  import rfm_pkg::*;

  localparam longint SCREEN_H = 512;
  localparam longint TEX_W    = 64;
  localparam longint TEX_H    = 64;
  localparam int     DRAIN    = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    item = '0;
  logic        done;
  out_word_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        tex_set_q;
  logic [23:0] player_dist_q;
  out_word_t   pending_texels[$];
  int          errors;
  int          words_sent;
  int          words_checked;
  int          idle_pct;

  raycast_floor_texel_mapper i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint blend_q816(longint wt, longint wall, longint pl);
    longint sum;
    sum = wt * wall + (64'sd65536 - wt) * pl;
    if (sum < 0) return 0;
    sum = sum >>> 16;
    return (sum > 64'sh FFFFFF) ? 64'sh FFFFFF : sum;
  endfunction

  function automatic out_word_t map_texel(in_word_t w);
    longint cx, cy, fr, rdx, rdy, wx, wy, denom, den, num, rowdist, wt, an, ad;
    longint pd, pos_x, pos_y;
    out_word_t r;
    cx = longint'(w.map_cell_x) * 65536;
    cy = longint'(w.map_cell_y) * 65536;
    fr = longint'(w.wall_hit_frac);
    rdx = longint'($signed(w.ray_dir_x));
    rdy = longint'($signed(w.ray_dir_y));
    pd = longint'(player_dist_q);
    if (!w.side && rdx > 0) begin
      wx = cx; wy = cy + fr;
    end else if (!w.side && rdx < 0) begin
      wx = cx + 65536; wy = cy + fr;
    end else if (w.side && rdy < 0) begin
      wx = cx + fr; wy = cy + 65536;
    end else begin
      wx = cx + fr; wy = cy;
    end
    r = '0;
    denom = 2 * longint'(w.row) - SCREEN_H;
    den = longint'(w.wall_distance) - pd;
    if (denom <= 0 || den == 0) begin
      r.bad_row = 1'b1;
    end else begin
      rowdist = (SCREEN_H * 65536) / denom;
      if (rowdist > 64'sh FFFFFF) rowdist = 64'sh FFFFFF;
      num = rowdist - pd;
      wt = 0;
      if (num != 0 && ((num > 0) == (den > 0))) begin
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        wt = (an * 65536) / ad;
        if (wt > 64'sh 3FFFF) wt = 64'sh 3FFFF;
      end
      pos_x = blend_q816(wt, wx, longint'(w.player_x));
      pos_y = blend_q816(wt, wy, longint'(w.player_y));
      r.texel_x = 6'(((pos_x * TEX_W) >>> 16) % TEX_W);
      r.texel_y = 6'(((pos_y * TEX_H) >>> 16) % TEX_H);
    end
    r.pixel_column    = w.column;
    r.floor_row       = w.row;
    r.ceiling_row     = (longint'(w.row) > SCREEN_H) ? 10'd0 : 10'(SCREEN_H - w.row);
    r.floor_texture   = tex_set_q ? FLOOR_TEX_B : FLOOR_TEX_A;
    r.ceiling_texture = tex_set_q ? CEIL_TEX_B : CEIL_TEX_A;
    r.bad_row         = r.bad_row;
    return r;
  endfunction

  task automatic field_check(string f, longint e, longint a);
    if (e != a) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d got %0d (word %0d)", f, e, a, words_checked);
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && done) begin
      if (pending_texels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %h", result);
      end else begin
        e = pending_texels.pop_front();
        field_check("pixel_column", e.pixel_column, result.pixel_column);
        field_check("floor_row", e.floor_row, result.floor_row);
        field_check("ceiling_row", e.ceiling_row, result.ceiling_row);
        field_check("texel_x", e.texel_x, result.texel_x);
        field_check("texel_y", e.texel_y, result.texel_y);
        field_check("floor_texture", e.floor_texture, result.floor_texture);
        field_check("ceiling_texture", e.ceiling_texture, result.ceiling_texture);
        field_check("bad_row", e.bad_row, result.bad_row);
        words_checked++;
      end
    end
  end

  task automatic send_word(in_word_t w);
    @(negedge clk);
    start <= 1'b1;
    item  <= w;
    while (busy) @(negedge clk);
    pending_texels.push_back(map_texel(w));
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_texels.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_TEXTURE_SET) tex_set_q = val[0];
    else player_dist_q = val[23:0];
  endtask

  function automatic in_word_t rand_word();
    in_word_t     w;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    if ($urandom_range(99) < 85) w.row = 9'($urandom_range(257, 511));
    case ($urandom_range(9))
      0: w.wall_distance = player_dist_q;
      1, 2: w.wall_distance = player_dist_q + 24'($urandom_range(0, 1 << 18)) - 24'(1 << 17);
      3: w.ray_dir_x = '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    idle_pct = 0;
    for (int k = 0; k < 22; k++) begin
      w = '0;
      w.column = (k % 2) ? 11'h7FF : 11'h0;
      w.map_cell_x = (k % 3 == 0) ? 8'hFF : 8'd12;
      w.map_cell_y = (k % 3 == 1) ? 8'hFF : 8'd7;
      w.wall_hit_frac = (k % 2) ? 16'hFFFF : 16'h4000;
      w.wall_distance = 24'h030000;
      w.player_x = 24'h058000;
      w.player_y = 24'h0A4000;
      w.row = 9'd400;
      case (k % 6)
        0: begin w.side = 0; w.ray_dir_x = 16'sh4000;  end
        1: begin w.side = 0; w.ray_dir_x = -16'sh4000; end
        2: begin w.side = 0; w.ray_dir_x = 16'sh0;     end
        3: begin w.side = 1; w.ray_dir_y = -16'sh8000; end
        4: begin w.side = 1; w.ray_dir_y = 16'sh7FFF;  end
        5: begin w.side = 1; w.ray_dir_y = 16'sh0;     end
        default: ;
      endcase
      case (k)
        6:  w.row = 9'd0;
        7:  w.row = 9'd256;
        8:  w.row = 9'd257;
        9:  w.row = 9'd511;
        10: w.wall_distance = player_dist_q;
        11: begin w.wall_distance = 24'hFFFFFF; w.player_x = 24'hFFFFFF;
                  w.player_y = 24'hFFFFFF; end
        12: w.wall_distance = 24'h000001;
        13: begin w.row = 9'd257; w.wall_distance = 24'h000001; end
        default: ;
      endcase
      send_word(w);
    end
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    repeat (n) send_word(rand_word());
  endtask

  initial begin
    errors = 0; words_sent = 0; words_checked = 0; idle_pct = 0;
    tex_set_q = 1'b0; player_dist_q = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    write_reg(REG_TEXTURE_SET, 32'd1);
    write_reg(REG_PLAYER_DIST, 32'h020000);
    test_directed();
    test_random(400, 0);
    write_reg(REG_TEXTURE_SET, 32'd0);
    write_reg(REG_PLAYER_DIST, 32'hFFFFFF);
    test_random(350, 54);
    write_reg(REG_PLAYER_DIST, 32'h0);
    test_random(350, 30);
    wait_drained();
    write_reg(REG_TEXTURE_SET, 32'd1);
    write_reg(REG_PLAYER_DIST, $urandom & 32'hFFFFFF);
    test_random(350, 0);
    wait_drained();
    $display("covered %0d pixel words, %0d results checked, over five register settings",
             words_sent, words_checked);
    $display("with back-to-back, sparse and drained input phases");
    if (errors == 0 && pending_texels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_texels.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
